/* hdl/quaternion_attitude_telemetry_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion attitude telemetry core
// Clocked implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ATTITUDE_TELEMETRY_CORE_ASSERT_SVH
`define QUATERNION_ATTITUDE_TELEMETRY_CORE_ASSERT_SVH

// Same-cycle implication
`define QAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qat assertion failed (same cycle)");

// Next-cycle implication
`define QAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qat assertion failed (next cycle)");

`endif

/* hdl/qat_pkg.sv */
// ----------------------------------------------------------------------------
// qat_pkg
// Types, widths, codes and tables shared by the telemetry core.
// ----------------------------------------------------------------------------
package qat_pkg;

    // Field widths
    localparam int Q_W      = 16;
    localparam int TIME_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int ANGLE_W  = 16;

    // Datapath widths
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 36;
    localparam int XY_W     = 38;
    localparam int Z_W      = 33;
    localparam int RAD_W    = 57;
    localparam int ROOT_W   = 29;
    localparam int RNUM_W   = 25;

    // CORDIC
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANG_TAB_LEN      = 24;
    localparam int ANG_FRAC         = 22;
    localparam logic signed [Z_W-1:0]   Z_HALF_TURN = Z_W'(754974720);
    localparam logic signed [ACC_W-1:0] ONE_Q28     = ACC_W'(268435456);

    // Frame constants
    localparam logic [BYTE_W-1:0] FRAME_SYNC = 8'hAA;
    localparam logic [BYTE_W-1:0] FRAME_ID   = 8'h01;
    localparam logic [BYTE_W-1:0] FRAME_PLEN = 8'd12;
    localparam logic signed [ANGLE_W-1:0] PITCH_LIMIT = 16'sd9000;

    typedef logic [3:0] t_byte_pos;
    localparam t_byte_pos B_SYNC      = 4'd0;
    localparam t_byte_pos B_ID        = 4'd1;
    localparam t_byte_pos B_LEN       = 4'd2;
    localparam t_byte_pos B_VAL_FIRST = 4'd3;
    localparam t_byte_pos B_VAL_LAST  = 4'd14;
    localparam t_byte_pos B_SUM       = 4'd15;

    // Product schedule
    typedef logic [3:0] t_prod_step;
    localparam t_prod_step P_Q0Q1 = 4'd0;
    localparam t_prod_step P_Q2Q3 = 4'd1;
    localparam t_prod_step P_Q1Q1 = 4'd2;
    localparam t_prod_step P_Q2Q2 = 4'd3;
    localparam t_prod_step P_Q3Q3 = 4'd4;
    localparam t_prod_step P_Q0Q3 = 4'd5;
    localparam t_prod_step P_Q1Q2 = 4'd6;
    localparam t_prod_step P_Q0Q2 = 4'd7;
    localparam t_prod_step P_Q3Q1 = 4'd8;
    localparam t_prod_step P_DONE = 4'd9;

    // Angle axes
    typedef logic [1:0] t_axis;
    localparam t_axis AX_ROLL  = 2'd0;
    localparam t_axis AX_PITCH = 2'd1;
    localparam t_axis AX_YAW   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_SQ,
        ST_SQRT,
        ST_ANGLE,
        ST_RATE,
        ST_SEND
    } t_state;

    // atan(2^-i) in degrees, Q22
    function automatic logic [27:0] atan_q22(input logic [4:0] idx);
        logic [27:0] v;
        case (idx)
            5'd0:  v = 28'd188743680;
            5'd1:  v = 28'd111421900;
            5'd2:  v = 28'd58872272;
            5'd3:  v = 28'd29884485;
            5'd4:  v = 28'd15000234;
            5'd5:  v = 28'd7507429;
            5'd6:  v = 28'd3754631;
            5'd7:  v = 28'd1877430;
            5'd8:  v = 28'd938729;
            5'd9:  v = 28'd469366;
            5'd10: v = 28'd234683;
            5'd11: v = 28'd117342;
            5'd12: v = 28'd58671;
            5'd13: v = 28'd29335;
            5'd14: v = 28'd14668;
            5'd15: v = 28'd7334;
            5'd16: v = 28'd3667;
            5'd17: v = 28'd1833;
            5'd18: v = 28'd917;
            5'd19: v = 28'd458;
            5'd20: v = 28'd229;
            5'd21: v = 28'd115;
            5'd22: v = 28'd57;
            5'd23: v = 28'd29;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/qat_in_if.sv */
// ----------------------------------------------------------------------------
// qat_in_if
// Quaternion sample channel: valid/ready with quaternion and timestamp.
// ----------------------------------------------------------------------------
interface qat_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [qat_pkg::Q_W-1:0]      quat_w;
    logic signed [qat_pkg::Q_W-1:0]      quat_x;
    logic signed [qat_pkg::Q_W-1:0]      quat_y;
    logic signed [qat_pkg::Q_W-1:0]      quat_z;
    logic        [qat_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, time_ms, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, time_ms, output ready);
endinterface

/* hdl/qat_out_if.sv */
// ----------------------------------------------------------------------------
// qat_out_if
// Telemetry byte channel: valid/ready with frame byte and end marker.
// ----------------------------------------------------------------------------
interface qat_out_if;
    logic                              valid;
    logic                              ready;
    logic [qat_pkg::BYTE_W-1:0]        out_byte;
    logic                              frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

/* hdl/qat_cordic.sv */
// ----------------------------------------------------------------------------
// qat_cordic
// Iterative vectoring CORDIC: atan2(y, x) in centidegrees, one step a cycle.
// ----------------------------------------------------------------------------
module qat_cordic #(
    parameter int STEPS = qat_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [qat_pkg::XY_W-1:0]     i_y,
    input  logic signed [qat_pkg::XY_W-1:0]     i_x,
    output logic                                o_done,
    output logic signed [qat_pkg::ANGLE_W-1:0]  o_angle
);
    localparam int XY_W = qat_pkg::XY_W;
    localparam int Z_W  = qat_pkg::Z_W;
    localparam int P_W  = Z_W + 7;
    localparam logic [4:0] LAST = 5'(STEPS - 1);

    logic                        r_busy, r_round, r_done, r_zero;
    logic signed [XY_W-1:0]      r_x, r_y;
    logic signed [Z_W-1:0]       r_z;
    logic [4:0]                  r_i;
    logic signed [qat_pkg::ANGLE_W-1:0] r_angle;

    logic signed [XY_W-1:0]      xs, ys, n_x, n_y;
    logic signed [Z_W-1:0]       ang, n_z;
    logic signed [P_W-1:0]       zx, prod;
    logic        [P_W-1:0]       mag;
    logic        [17:0]          qr;
    logic signed [qat_pkg::ANGLE_W-1:0] sat_angle;

    // One micro-rotation toward the x axis
    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        ang = Z_W'(qat_pkg::atan_q22(r_i));
        if (r_y > 0) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end
    end

    // Scale degrees by 100, round half away from zero, saturate
    always_comb begin
        zx   = {{(P_W-Z_W){r_z[Z_W-1]}}, r_z};
        prod = (zx <<< 6) + (zx <<< 5) + (zx <<< 2);
        mag  = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
        qr   = 18'((mag + P_W'(2097152)) >> 22);
        if (!prod[P_W-1]) begin
            sat_angle = (qr > 18'd32767) ? 16'sd32767 : 16'(qr);
        end else begin
            sat_angle = (qr > 18'd32768) ? -16'sd32768 : 16'(-qr);
        end
    end

    // Sequence load, iterate and round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 1'b0;
            end else if (r_busy) begin
                if (r_i == LAST) begin
                    r_busy  <= 1'b0;
                    r_round <= 1'b1;
                end
            end else if (r_round) begin
                r_round <= 1'b0;
                r_done  <= 1'b1;
            end
        end
    end

    // Hold the vector and angle accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= 5'd0;
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= (i_y >= 0) ? qat_pkg::Z_HALF_TURN : -qat_pkg::Z_HALF_TURN;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + 5'd1;
        end
        if (r_round) begin
            r_angle <= r_zero ? '0 : sat_angle;
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;
endmodule

/* hdl/qat_isqrt.sv */
// ----------------------------------------------------------------------------
// qat_isqrt
// Integer square root, two radicand bits per cycle (digit by digit).
// ----------------------------------------------------------------------------
module qat_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [qat_pkg::RAD_W-1:0]       i_rad,
    output logic                            o_done,
    output logic [qat_pkg::ROOT_W-1:0]      o_root
);
    localparam int RAD_W = qat_pkg::RAD_W;

    logic               r_busy, r_done;
    logic [RAD_W-1:0]   r_n, r_bit;
    logic [RAD_W:0]     r_res;
    logic [RAD_W:0]     trial;

    assign trial = r_res + {1'b0, r_bit};

    // Advance one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_rad;
            r_res <= '0;
            r_bit <= {1'b1, {(RAD_W-1){1'b0}}};
        end else if (r_busy) begin
            if ({1'b0, r_n} >= trial) begin
                r_n   <= r_n - trial[RAD_W-1:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[qat_pkg::ROOT_W-1:0];
endmodule

/* hdl/qat_rdiv.sv */
// ----------------------------------------------------------------------------
// qat_rdiv
// Rounded signed divide by elapsed time, restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module qat_rdiv (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [qat_pkg::RNUM_W-1:0]   i_num,
    input  logic        [qat_pkg::TIME_W-1:0]   i_den,
    output logic                                o_done,
    output logic signed [qat_pkg::ANGLE_W-1:0]  o_quot
);
    localparam int DIV_W = qat_pkg::TIME_W + 2;
    localparam int DVS_W = qat_pkg::TIME_W + 1;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic               r_busy, r_done, r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_rem, r_quo;
    logic [DVS_W-1:0]   r_dvs;

    logic [qat_pkg::RNUM_W-1:0] mag;
    logic [DIV_W-1:0]   shifted;
    logic               fits;

    assign mag     = i_num[qat_pkg::RNUM_W-1] ? qat_pkg::RNUM_W'(-i_num)
                                              : qat_pkg::RNUM_W'(i_num);
    assign shifted = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    // Sequence the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Divide (2|n| + d) by 2d
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIV_W'({mag, 1'b0}) + DIV_W'(i_den);
            r_rem <= '0;
            r_dvs <= {i_den, 1'b0};
            r_neg <= i_num[qat_pkg::RNUM_W-1];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? shifted - DIV_W'(r_dvs) : shifted;
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Apply sign and saturate to int16
    always_comb begin
        if (!r_neg) begin
            o_quot = (r_quo > DIV_W'(32767)) ? 16'sd32767 : 16'(r_quo);
        end else begin
            o_quot = (r_quo > DIV_W'(32768)) ? -16'sd32768 : 16'(-r_quo);
        end
    end

    assign o_done = r_done;
endmodule

/* hdl/quaternion_attitude_telemetry_core.sv */
// ----------------------------------------------------------------------------
// quaternion_attitude_telemetry_core
// Quaternion to roll/pitch/yaw with rates, sent as a 16-byte telemetry frame.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | transfer
//  i_in     | in  | quat_w/x/y/z (Q2.14), time_ms (32 b)   | valid & ready
//  o_out    | out | out_byte (8 b), frame_end              | valid & ready
//
//  One sample passes through the accept step, the product steps, the pitch square,
//  the square root (skipped when pitch saturates), one CORDIC run per angle (none
//  for pitch when it saturates), one rate divide per axis (none when the elapsed
//  time is zero) and 16 byte transfers, and it also waits through output stalls.
//  i_in.ready is high only while no sample is in flight.
//  Reset is synchronous and clears the previous-sample state; no clearing pass.
//  A stalled o_out holds the current byte until taken.
// ----------------------------------------------------------------------------
`include "quaternion_attitude_telemetry_core_assert.svh"

module quaternion_attitude_telemetry_core #(
    parameter int CORDIC_STEPS = qat_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qat_in_if.sink      i_in,
    qat_out_if.source   o_out
);
    localparam int ACC_W  = qat_pkg::ACC_W;
    localparam int XY_W   = qat_pkg::XY_W;
    localparam int MUL_W  = qat_pkg::MUL_W;
    localparam int PROD_W = qat_pkg::PROD_W;
    localparam int RAD_W  = qat_pkg::RAD_W;

    qat_pkg::t_state                r_state, n_state;
    qat_pkg::t_prod_step            r_cnt;
    qat_pkg::t_axis                 r_axis;
    qat_pkg::t_byte_pos             r_byte_idx;
    logic                           r_cordic_start, r_sqrt_start, r_div_start;
    logic                           r_pitch_sat;
    logic signed [15:0]             r_prev [3];
    logic [qat_pkg::TIME_W-1:0]     r_prev_time;

    logic signed [qat_pkg::Q_W-1:0] r_q0, r_q1, r_q2, r_q3;
    logic [qat_pkg::TIME_W-1:0]     r_now, r_dt;
    logic signed [ACC_W-1:0]        r_sr, r_cr, r_sy, r_cy, r_sp;
    logic signed [PROD_W-1:0]       r_prod;
    logic [RAD_W-1:0]               r_rad;
    logic [qat_pkg::ROOT_W-1:0]     r_root;
    logic signed [15:0]             r_val [6];
    logic [7:0]                     r_sum;

    logic                           in_xfer, out_xfer;
    logic signed [MUL_W-1:0]        mul_a, mul_b;
    logic signed [ACC_W-1:0]        prod2;
    qat_pkg::t_prod_step            acc_step;
    logic                           pitch_sat;
    logic signed [16:0]             diff;
    logic signed [XY_W-1:0]         cd_y, cd_x;
    logic                           cordic_done, sqrt_done, div_done;
    logic signed [15:0]             cordic_angle, div_quot;
    logic [qat_pkg::ROOT_W-1:0]     sqrt_root;
    logic [3:0]                     val_off;
    logic [2:0]                     val_sel;
    logic [7:0]                     frame_byte;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign pitch_sat = (r_sp >= qat_pkg::ONE_Q28) || (r_sp <= -qat_pkg::ONE_Q28);
    assign prod2    = {r_prod[ACC_W-2:0], 1'b0};
    assign acc_step = r_cnt - qat_pkg::t_prod_step'(1);
    assign diff     = {r_val[3'(r_axis)][15], r_val[3'(r_axis)]}
                    - {r_prev[r_axis][15], r_prev[r_axis]};

    // Select shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            qat_pkg::ST_PROD: begin
                unique case (r_cnt) inside
                    qat_pkg::P_Q0Q1: begin mul_a = MUL_W'(r_q0); mul_b = MUL_W'(r_q1); end
                    qat_pkg::P_Q2Q3: begin mul_a = MUL_W'(r_q2); mul_b = MUL_W'(r_q3); end
                    qat_pkg::P_Q1Q1: begin mul_a = MUL_W'(r_q1); mul_b = MUL_W'(r_q1); end
                    qat_pkg::P_Q2Q2: begin mul_a = MUL_W'(r_q2); mul_b = MUL_W'(r_q2); end
                    qat_pkg::P_Q3Q3: begin mul_a = MUL_W'(r_q3); mul_b = MUL_W'(r_q3); end
                    qat_pkg::P_Q0Q3: begin mul_a = MUL_W'(r_q0); mul_b = MUL_W'(r_q3); end
                    qat_pkg::P_Q1Q2: begin mul_a = MUL_W'(r_q1); mul_b = MUL_W'(r_q2); end
                    qat_pkg::P_Q0Q2: begin mul_a = MUL_W'(r_q0); mul_b = MUL_W'(r_q2); end
                    qat_pkg::P_Q3Q1: begin mul_a = MUL_W'(r_q3); mul_b = MUL_W'(r_q1); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            qat_pkg::ST_SQ: begin
                mul_a = r_sp[MUL_W-1:0];
                mul_b = r_sp[MUL_W-1:0];
            end
            qat_pkg::ST_RATE: begin
                mul_a = MUL_W'(diff);
                mul_b = MUL_W'(100);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Route the CORDIC operands for the current axis
    always_comb begin
        unique case (r_axis)
            qat_pkg::AX_PITCH: begin
                cd_y = XY_W'(r_sp);
                cd_x = XY_W'({1'b0, r_root});
            end
            qat_pkg::AX_YAW: begin
                cd_y = XY_W'(r_sy);
                cd_x = XY_W'(r_cy);
            end
            default: begin
                cd_y = XY_W'(r_sr);
                cd_x = XY_W'(r_cr);
            end
        endcase
    end

    qat_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cordic_start),
        .i_y     (cd_y),
        .i_x     (cd_x),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    qat_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_rad   (r_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    qat_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_prod[qat_pkg::RNUM_W-1:0]),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qat_pkg::ST_IDLE:  if (in_xfer) n_state = qat_pkg::ST_PROD;
            qat_pkg::ST_PROD:  if (r_cnt == qat_pkg::P_DONE) n_state = qat_pkg::ST_SQ;
            qat_pkg::ST_SQ: begin
                if (r_cnt != qat_pkg::P_Q0Q1) begin
                    n_state = pitch_sat ? qat_pkg::ST_ANGLE : qat_pkg::ST_SQRT;
                end
            end
            qat_pkg::ST_SQRT:  if (sqrt_done) n_state = qat_pkg::ST_ANGLE;
            qat_pkg::ST_ANGLE: begin
                if (cordic_done && r_axis == qat_pkg::AX_YAW) n_state = qat_pkg::ST_RATE;
            end
            qat_pkg::ST_RATE: begin
                if (r_dt == '0) begin
                    n_state = qat_pkg::ST_SEND;
                end else if (div_done && r_axis == qat_pkg::AX_YAW) begin
                    n_state = qat_pkg::ST_SEND;
                end
            end
            qat_pkg::ST_SEND: begin
                if (out_xfer && r_byte_idx == qat_pkg::B_SUM) n_state = qat_pkg::ST_IDLE;
            end
            default: n_state = qat_pkg::ST_IDLE;
        endcase
    end

    // Sequencer counters, unit starts and previous-sample state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt          <= qat_pkg::P_Q0Q1;
            r_axis         <= qat_pkg::AX_ROLL;
            r_byte_idx     <= qat_pkg::B_SYNC;
            r_cordic_start <= 1'b0;
            r_sqrt_start   <= 1'b0;
            r_div_start    <= 1'b0;
            r_pitch_sat    <= 1'b0;
            r_prev_time    <= '0;
            r_prev[0]      <= '0;
            r_prev[1]      <= '0;
            r_prev[2]      <= '0;
        end else begin
            r_cordic_start <= 1'b0;
            r_sqrt_start   <= 1'b0;
            r_div_start    <= 1'b0;
            unique case (r_state)
                qat_pkg::ST_IDLE: begin
                    if (in_xfer) r_cnt <= qat_pkg::P_Q0Q1;
                end
                qat_pkg::ST_PROD: begin
                    r_cnt <= (r_cnt == qat_pkg::P_DONE) ? qat_pkg::P_Q0Q1
                                                        : r_cnt + qat_pkg::t_prod_step'(1);
                end
                qat_pkg::ST_SQ: begin
                    if (r_cnt == qat_pkg::P_Q0Q1) begin
                        r_cnt <= qat_pkg::P_Q2Q3;
                    end else begin
                        r_cnt       <= qat_pkg::P_Q0Q1;
                        r_pitch_sat <= pitch_sat;
                        r_axis      <= qat_pkg::AX_ROLL;
                        if (pitch_sat) r_cordic_start <= 1'b1;
                        else           r_sqrt_start   <= 1'b1;
                    end
                end
                qat_pkg::ST_SQRT: begin
                    if (sqrt_done) r_cordic_start <= 1'b1;
                end
                qat_pkg::ST_ANGLE: begin
                    if (cordic_done) begin
                        if (r_axis == qat_pkg::AX_YAW) begin
                            r_axis <= qat_pkg::AX_ROLL;
                            r_cnt  <= qat_pkg::P_Q0Q1;
                        end else begin
                            r_axis <= (r_axis == qat_pkg::AX_ROLL && !r_pitch_sat)
                                      ? qat_pkg::AX_PITCH : qat_pkg::AX_YAW;
                            r_cordic_start <= 1'b1;
                        end
                    end
                end
                qat_pkg::ST_RATE: begin
                    if (r_dt == '0 || (div_done && r_axis == qat_pkg::AX_YAW)) begin
                        r_prev[0]   <= r_val[0];
                        r_prev[1]   <= r_val[1];
                        r_prev[2]   <= r_val[2];
                        r_prev_time <= r_now;
                        r_byte_idx  <= qat_pkg::B_SYNC;
                    end else begin
                        unique case (r_cnt) inside
                            qat_pkg::P_Q0Q1: r_cnt <= qat_pkg::P_Q2Q3;
                            qat_pkg::P_Q2Q3: begin
                                r_div_start <= 1'b1;
                                r_cnt       <= qat_pkg::P_Q1Q1;
                            end
                            default: begin
                                if (div_done) begin
                                    r_axis <= r_axis + qat_pkg::t_axis'(1);
                                    r_cnt  <= qat_pkg::P_Q0Q1;
                                end
                            end
                        endcase
                    end
                end
                qat_pkg::ST_SEND: begin
                    if (out_xfer) r_byte_idx <= r_byte_idx + qat_pkg::t_byte_pos'(1);
                end
                default: r_cnt <= qat_pkg::P_Q0Q1;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            qat_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    r_q0  <= i_in.quat_w;
                    r_q1  <= i_in.quat_x;
                    r_q2  <= i_in.quat_y;
                    r_q3  <= i_in.quat_z;
                    r_now <= i_in.time_ms;
                    r_dt  <= (r_prev_time != '0) ? i_in.time_ms - r_prev_time : '0;
                    r_sr  <= '0;
                    r_cr  <= qat_pkg::ONE_Q28;
                    r_sy  <= '0;
                    r_cy  <= qat_pkg::ONE_Q28;
                    r_sp  <= '0;
                end
            end
            qat_pkg::ST_PROD: begin
                if (r_cnt != qat_pkg::P_Q0Q1) begin
                    unique case (acc_step) inside
                        qat_pkg::P_Q0Q1, qat_pkg::P_Q2Q3: r_sr <= r_sr + prod2;
                        qat_pkg::P_Q1Q1:                  r_cr <= r_cr - prod2;
                        qat_pkg::P_Q2Q2: begin
                            r_cr <= r_cr - prod2;
                            r_cy <= r_cy - prod2;
                        end
                        qat_pkg::P_Q3Q3:                  r_cy <= r_cy - prod2;
                        qat_pkg::P_Q0Q3, qat_pkg::P_Q1Q2: r_sy <= r_sy + prod2;
                        qat_pkg::P_Q0Q2:                  r_sp <= r_sp + prod2;
                        qat_pkg::P_Q3Q1:                  r_sp <= r_sp - prod2;
                        default:                          r_sp <= r_sp;
                    endcase
                end
            end
            qat_pkg::ST_SQ: begin
                if (r_cnt != qat_pkg::P_Q0Q1) begin
                    r_rad <= {1'b1, {(RAD_W-1){1'b0}}} - r_prod[RAD_W-1:0];
                    if (r_sp >= qat_pkg::ONE_Q28) begin
                        r_val[1] <= qat_pkg::PITCH_LIMIT;
                    end else if (r_sp <= -qat_pkg::ONE_Q28) begin
                        r_val[1] <= -qat_pkg::PITCH_LIMIT;
                    end
                end
            end
            qat_pkg::ST_SQRT: begin
                if (sqrt_done) r_root <= sqrt_root;
            end
            qat_pkg::ST_ANGLE: begin
                if (cordic_done) r_val[3'(r_axis)] <= cordic_angle;
            end
            qat_pkg::ST_RATE: begin
                if (r_dt == '0) begin
                    r_val[3] <= '0;
                    r_val[4] <= '0;
                    r_val[5] <= '0;
                end else if (div_done) begin
                    r_val[3'(r_axis) + 3'd3] <= div_quot;
                end
            end
            qat_pkg::ST_SEND: begin
                if (out_xfer) begin
                    r_sum <= (r_byte_idx == qat_pkg::B_SYNC) ? 8'd0 : r_sum + frame_byte;
                end
            end
            default: r_sum <= r_sum;
        endcase
    end

    // Pick the frame byte
    assign val_off = r_byte_idx - qat_pkg::B_VAL_FIRST;
    assign val_sel = val_off[3:1];
    always_comb begin
        unique case (r_byte_idx) inside
            qat_pkg::B_SYNC: frame_byte = qat_pkg::FRAME_SYNC;
            qat_pkg::B_ID:   frame_byte = qat_pkg::FRAME_ID;
            qat_pkg::B_LEN:  frame_byte = qat_pkg::FRAME_PLEN;
            [qat_pkg::B_VAL_FIRST:qat_pkg::B_VAL_LAST]: begin
                frame_byte = val_off[0] ? r_val[val_sel][15:8] : r_val[val_sel][7:0];
            end
            default: frame_byte = r_sum;
        endcase
    end

    assign i_in.ready      = (r_state == qat_pkg::ST_IDLE);
    assign o_out.valid     = (r_state == qat_pkg::ST_SEND);
    assign o_out.out_byte  = frame_byte;
    assign o_out.frame_end = (r_byte_idx == qat_pkg::B_SUM);

    // Checks
    `QAT_ASSERT_IMPL(a_no_accept_while_sending, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `QAT_ASSERT_NEXT(a_frame_end_frees_input, i_clk, i_rst_n, out_xfer && o_out.frame_end, i_in.ready)
    `QAT_ASSERT_NEXT(a_accept_no_output, i_clk, i_rst_n, in_xfer, !o_out.valid)
    `QAT_ASSERT_IMPL(a_cordic_done_in_angle, i_clk, i_rst_n, cordic_done, r_state == qat_pkg::ST_ANGLE)
endmodule
